/* hw/rtl/xcfp_pkg.sv */
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants of the xor checked frame parser: status codes,
// configuration register indexes, configuration and result records.
// ----------------------------------------------------------------------------
package xcfp_pkg;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_TOO_SHORT     = 3'd1,
        ST_BAD_HEADER    = 3'd2,
        ST_BAD_TAIL      = 3'd3,
        ST_BCC_FAIL      = 3'd4,
        ST_ADDR_MISMATCH = 3'd5
    } status_t;

    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_DEVICE_ADDRESS = 2'd0;
    localparam cfg_index_t CFG_HEADER_BYTE    = 2'd1;
    localparam cfg_index_t CFG_TAIL_BYTE      = 2'd2;

    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h01;
    localparam logic [7:0] HEADER_BYTE_RST    = 8'h7A;
    localparam logic [7:0] TAIL_BYTE_RST      = 8'h00;

    localparam int MIN_FRAME       = 5;
    localparam int MIN_VALUE_FRAME = 9;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] header_byte;
        logic [7:0] tail_byte;
    } cfg_t;

    // packed from the top down, so status ends up in the lowest bits
    typedef struct packed {
        logic [7:0]         address_seen;
        logic [7:0]         header_seen;
        logic [7:0]         received_bcc;
        logic [7:0]         computed_bcc;
        logic [5:0]         frame_length;
        logic signed [31:0] reply_value;
        logic [7:0]         frame_type;
        logic               checksum_ok;
        logic               frame_valid;
        status_t            status;
    } result_t;

    localparam int RESULT_W   = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

/* hw/rtl/xcfp_in_stage.sv */
// ----------------------------------------------------------------------------
// xcfp_in_stage
// Input register: holds one accepted item until the frame logic takes it.
// ----------------------------------------------------------------------------
module xcfp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       advance,
    output logic       item_valid,
    output logic       item_func,
    output logic [7:0] item_byte
);
    logic       valid_reg, valid_next;
    logic       func_reg;
    logic [7:0] byte_reg;
    logic       take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            func_reg <= s_tuser;
            byte_reg <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_func  = func_reg;
    assign item_byte  = byte_reg;

endmodule

/* hw/rtl/xcfp_frame_acc.sv */
// ----------------------------------------------------------------------------
// xcfp_frame_acc
// Frame state: collects header, address, type, value bytes, running xor and
// the last two bytes; on end of reception checks the frame and clears.
// ----------------------------------------------------------------------------
module xcfp_frame_acc #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  xcfp_pkg::cfg_t   cfg,
    input  logic             item_valid,
    input  logic             item_func,
    input  logic [7:0]       item_byte,
    input  logic             out_ready,
    output logic             advance,
    output logic             res_valid,
    output xcfp_pkg::result_t res
);
    import xcfp_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES + 1);

    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    xor_reg, xor_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    second_reg, second_next;
    logic [7:0]    third_reg, third_next;
    logic [31:0]   value_reg, value_next;
    logic [7:0]    last_reg, last_next;
    logic [7:0]    prev_reg, prev_next;

    logic          take_byte;
    logic          end_frame;
    logic [7:0]    cbcc;

    assign advance   = item_valid && (!item_func || out_ready);
    assign take_byte = item_valid && !item_func && (count_reg < CW'(BUFFER_BYTES));
    assign end_frame = item_valid && item_func && out_ready;
    assign res_valid = end_frame;

    always_comb begin
        count_next  = count_reg;
        xor_next    = xor_reg;
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        prev_next   = prev_reg;
        if (end_frame) begin
            count_next  = '0;
            xor_next    = '0;
            first_next  = '0;
            second_next = '0;
            third_next  = '0;
            value_next  = '0;
            last_next   = '0;
            prev_next   = '0;
        end else if (take_byte) begin
            case (count_reg)
                CW'(0):  first_next         = item_byte;
                CW'(1):  second_next        = item_byte;
                CW'(2):  third_next         = item_byte;
                CW'(3):  value_next[31:24]  = item_byte;
                CW'(4):  value_next[23:16]  = item_byte;
                CW'(5):  value_next[15:8]   = item_byte;
                CW'(6):  value_next[7:0]    = item_byte;
                default: value_next         = value_reg;
            endcase
            prev_next  = last_reg;
            last_next  = item_byte;
            xor_next   = xor_reg ^ item_byte;
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            xor_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            third_reg  <= '0;
            value_reg  <= '0;
            last_reg   <= '0;
            prev_reg   <= '0;
        end else begin
            count_reg  <= count_next;
            xor_reg    <= xor_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            value_reg  <= value_next;
            last_reg   <= last_next;
            prev_reg   <= prev_next;
        end
    end

    // bcc byte and tail are both in the running xor, take them back out
    assign cbcc = xor_reg ^ last_reg ^ prev_reg;

    always_comb begin
        res              = '0;
        res.frame_length = 6'(count_reg);
        res.header_seen  = first_reg;
        res.address_seen = second_reg;
        if (count_reg < CW'(MIN_FRAME)) begin
            res.status = ST_TOO_SHORT;
        end else if (first_reg != cfg.header_byte) begin
            res.status = ST_BAD_HEADER;
        end else if (last_reg != cfg.tail_byte) begin
            res.status = ST_BAD_TAIL;
        end else begin
            res.computed_bcc = cbcc;
            res.received_bcc = prev_reg;
            if (cbcc != prev_reg) begin
                res.status = ST_BCC_FAIL;
            end else if (second_reg != cfg.device_address) begin
                res.status      = ST_ADDR_MISMATCH;
                res.frame_valid = 1'b1;
                res.checksum_ok = 1'b1;
            end else begin
                res.status      = ST_OK;
                res.frame_valid = 1'b1;
                res.checksum_ok = 1'b1;
                res.frame_type  = third_reg;
                if (count_reg >= CW'(MIN_VALUE_FRAME)) begin
                    res.reply_value = value_reg;
                end
            end
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(BUFFER_BYTES))
        else $error("byte count beyond buffer size");

    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        end_frame |=> (count_reg == '0 && xor_reg == '0))
        else $error("frame state not cleared after end of reception");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CW'(BUFFER_BYTES) && !end_frame) |=> $stable(xor_reg))
        else $error("byte taken into a full frame");

endmodule

/* hw/rtl/xcfp_out_reg.sv */
// ----------------------------------------------------------------------------
// xcfp_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module xcfp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  xcfp_pkg::result_t res,
    output logic              out_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output xcfp_pkg::result_t m_res
);
    import xcfp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    a_valid_means_ck: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (res_reg.frame_valid == res_reg.checksum_ok))
        else $error("frame_valid and checksum_ok disagree");

    a_type_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.status != ST_OK) |->
            (res_reg.frame_type == '0 && res_reg.reply_value == '0))
        else $error("type or value reported on a failed frame");

endmodule

/* hw/rtl/xor_checked_frame_parser.sv */
// path: an accepted end item waits in the input register, then its result is registered in the result register
// throughput: one item per cycle while no end item waits on the result side; byte items never wait on the result side
// an end item waits in the input register while an earlier result is untaken
// reset: aresetn synchronous active low; clears frame state, item valids and
// loads the configuration registers with their defaults
// ----------------------------------------------------------------------------
// xor_checked_frame_parser
// Serial frame parser with xor bcc check, header, tail and address match.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  xcfp_pkg::cfg_index_t                cfg_index,
    input  logic [7:0]                          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // rx_byte
    input  logic                                s_tuser,  // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status, frame_valid, checksum_ok, frame_type, reply_value, frame_length,
    // computed_bcc, received_bcc, header_seen, address_seen, zero fill
    output logic [xcfp_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import xcfp_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       item_valid, item_func;
    logic [7:0] item_byte;
    logic       advance, res_valid, out_ready;
    result_t    res, m_res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_next.device_address = cfg_wdata;
                CFG_HEADER_BYTE:    cfg_next.header_byte    = cfg_wdata;
                CFG_TAIL_BYTE:      cfg_next.tail_byte      = cfg_wdata;
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RST;
            cfg_reg.header_byte    <= HEADER_BYTE_RST;
            cfg_reg.tail_byte      <= TAIL_BYTE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    xcfp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item_func  (item_func),
        .item_byte  (item_byte)
    );

    xcfp_frame_acc #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_func  (item_func),
        .item_byte  (item_byte),
        .out_ready  (out_ready),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    xcfp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {{(OUT_DATA_W - RESULT_W){1'b0}}, m_res};

endmodule
